// File: rtl/sahd_pkg.sv
// Shared types and constants for the sound activity hysteresis detector.
// Used by sound_activity_hysteresis_detector_unit and its bench; no other dependencies.
`timescale 1ns / 1ps

package sahd_pkg;

  localparam int LEVEL_W   = 16;
  localparam int TIME_W    = 32;
  localparam int RUN_W     = 8;
  localparam int GRACE_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int IN_DATA_W = 64;   // mean, peak, time
  localparam int OUT_DATA_W = 40;  // 35 bits of fields, padded to whole bytes

  localparam logic [CFG_IDX_W-1:0] CFG_START_TH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE    = 2'd3;

  localparam logic [LEVEL_W-1:0] START_TH_RST = 16'd500;
  localparam logic [LEVEL_W-1:0] STOP_TH_RST  = 16'd300;
  localparam logic [RUN_W-1:0]   DEBOUNCE_RST = 8'd3;
  localparam logic [GRACE_W-1:0] GRACE_RST    = 16'd500;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  typedef enum logic [1:0] {
    EDGE_NONE  = 2'd0,
    EDGE_START = 2'd1,
    EDGE_END   = 2'd2
  } edge_t;

  function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] run);
    run_inc = (run == RUN_MAX) ? RUN_MAX : run + RUN_W'(1);
  endfunction

endpackage

// File: rtl/sound_activity_hysteresis_detector_unit.sv
// Sound activity detector: level reports in, active flag and edge code out.
// Depends on sahd_pkg for widths, register indexes and edge codes.
// Throughput: one word per cycle unless out_tready holds back the result register;
//   input register, one pass of compares and counter updates, then the result register.
// Reset (rst_n low, synchronous): config takes its default values, the
//   active flag, stream-live flag, run counters and held levels clear.
`timescale 1ns / 1ps

module sound_activity_hysteresis_detector_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sahd_pkg::IN_DATA_W-1:0]    in_tdata,   // mean_level, peak_level, time_ms
  input  logic                              in_tuser,   // func
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sahd_pkg::OUT_DATA_W-1:0]   out_tdata,  // sound_active, edge_res,
                                                        // last_mean, last_peak, zero pad
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sahd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sahd_pkg::CFG_DAT_W-1:0]    cfg_data
);

  // configuration
  logic [sahd_pkg::LEVEL_W-1:0] start_th_r, stop_th_r;
  logic [sahd_pkg::RUN_W-1:0]   debounce_r;
  logic [sahd_pkg::GRACE_W-1:0] grace_r;

  // input register
  logic                         s1_valid_r;
  logic                         s1_func_r;
  logic [sahd_pkg::LEVEL_W-1:0] s1_mean_r, s1_peak_r;
  logic [sahd_pkg::TIME_W-1:0]  s1_time_r;

  // detector state
  logic                         active_r, active_nxt;
  logic                         live_r, live_nxt;
  logic [sahd_pkg::RUN_W-1:0]   loud_run_r, loud_run_nxt;
  logic [sahd_pkg::RUN_W-1:0]   quiet_run_r, quiet_run_nxt;
  logic [sahd_pkg::TIME_W-1:0]  win_start_r, win_start_nxt;
  logic [sahd_pkg::LEVEL_W-1:0] held_mean_r, held_mean_nxt;
  logic [sahd_pkg::LEVEL_W-1:0] held_peak_r, held_peak_nxt;
  sahd_pkg::edge_t              edge_nxt;

  // result register
  logic                         out_valid_r;
  sahd_pkg::edge_t              out_edge_r;
  logic                         out_active_r;
  logic [sahd_pkg::LEVEL_W-1:0] out_mean_r, out_peak_r;

  logic                         s1_adv;
  logic [sahd_pkg::RUN_W-1:0]   need;
  logic [sahd_pkg::TIME_W-1:0]  elapsed;

  assign cfg_ready  = 1'b1;
  assign s1_adv     = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sahd_pkg::OUT_DATA_W - 35){1'b0}}, out_peak_r, out_mean_r,
                       out_edge_r, out_active_r};

  assign need = (debounce_r == '0) ? sahd_pkg::RUN_W'(1) : debounce_r;

  always_comb begin
    active_nxt    = active_r;
    live_nxt      = live_r;
    loud_run_nxt  = loud_run_r;
    quiet_run_nxt = quiet_run_r;
    win_start_nxt = win_start_r;
    held_mean_nxt = held_mean_r;
    held_peak_nxt = held_peak_r;
    edge_nxt      = sahd_pkg::EDGE_NONE;
    elapsed       = '0;
    if (s1_func_r) begin
      // pause: drop the runs and rearm the grace window
      live_nxt      = 1'b0;
      loud_run_nxt  = '0;
      quiet_run_nxt = '0;
    end else begin
      if (!live_r) begin
        // first report after reset or pause: silent forced drop
        live_nxt      = 1'b1;
        win_start_nxt = s1_time_r;
        loud_run_nxt  = '0;
        quiet_run_nxt = '0;
        active_nxt    = 1'b0;
      end
      elapsed = s1_time_r - win_start_nxt;
      if (!active_nxt) begin
        quiet_run_nxt = '0;
        loud_run_nxt  = (s1_mean_r >= start_th_r) ? sahd_pkg::run_inc(loud_run_nxt) : '0;
        if (elapsed >= {{(sahd_pkg::TIME_W - sahd_pkg::GRACE_W){1'b0}}, grace_r} &&
            loud_run_nxt >= need) begin
          active_nxt   = 1'b1;
          loud_run_nxt = '0;
          edge_nxt     = sahd_pkg::EDGE_START;
        end
      end else begin
        loud_run_nxt  = '0;
        quiet_run_nxt = (s1_mean_r <= stop_th_r) ? sahd_pkg::run_inc(quiet_run_nxt) : '0;
        if (quiet_run_nxt >= need) begin
          active_nxt    = 1'b0;
          quiet_run_nxt = '0;
          edge_nxt      = sahd_pkg::EDGE_END;
        end
      end
      held_mean_nxt = s1_mean_r;
      held_peak_nxt = s1_peak_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_th_r <= sahd_pkg::START_TH_RST;
      stop_th_r  <= sahd_pkg::STOP_TH_RST;
      debounce_r <= sahd_pkg::DEBOUNCE_RST;
      grace_r    <= sahd_pkg::GRACE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sahd_pkg::CFG_START_TH: start_th_r <= cfg_data;
        sahd_pkg::CFG_STOP_TH:  stop_th_r  <= cfg_data;
        sahd_pkg::CFG_DEBOUNCE: debounce_r <= cfg_data[sahd_pkg::RUN_W-1:0];
        sahd_pkg::CFG_GRACE:    grace_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: payload loads on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      s1_func_r <= in_tuser;
      s1_mean_r <= in_tdata[15:0];
      s1_peak_r <= in_tdata[31:16];
      s1_time_r <= in_tdata[63:32];
    end
  end

  // state and result register advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      live_r      <= 1'b0;
      loud_run_r  <= '0;
      quiet_run_r <= '0;
      win_start_r <= '0;
      held_mean_r <= '0;
      held_peak_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv && s1_valid_r) begin
        active_r    <= active_nxt;
        live_r      <= live_nxt;
        loud_run_r  <= loud_run_nxt;
        quiet_run_r <= quiet_run_nxt;
        win_start_r <= win_start_nxt;
        held_mean_r <= held_mean_nxt;
        held_peak_r <= held_peak_nxt;
      end
    end
    if (s1_adv && s1_valid_r) begin
      out_active_r <= active_nxt;
      out_edge_r   <= edge_nxt;
      out_mean_r   <= held_mean_nxt;
      out_peak_r   <= held_peak_nxt;
    end
  end

  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_edge_r == sahd_pkg::EDGE_START |-> out_active_r)
    else $error("start edge without active flag");

  a_end_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_edge_r == sahd_pkg::EDGE_END |-> !out_active_r)
    else $error("end edge with active flag");

  a_pause_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_valid_r && s1_func_r |=> out_edge_r == sahd_pkg::EDGE_NONE && !live_r)
    else $error("pause produced an edge or left stream live");

  a_one_run: assert property (@(posedge clk) disable iff (!rst_n)
    loud_run_r == '0 || quiet_run_r == '0)
    else $error("loud and quiet runs both counting");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv && s1_valid_r) |=> $stable(active_r) && $stable(loud_run_r)
                                && $stable(quiet_run_r))
    else $error("detector state moved without a word");

endmodule

// File: dv/tb_sound_activity_hysteresis_detector_unit.sv
// Self-checking bench for sound_activity_hysteresis_detector_unit: a directed table, then
// random level-report streams under several threshold, debounce and grace settings.
// Depends on sahd_pkg and the unit RTL only; results are checked against an inline predictor.
`timescale 1ns / 1ps

module tb_sound_activity_hysteresis_detector_unit;
  import sahd_pkg::*;

  typedef struct packed {
    logic                active;
    edge_t               edge_code;
    logic [LEVEL_W-1:0]  mean;
    logic [LEVEL_W-1:0]  peak;
  } status_t;

  typedef struct {
    bit                  pause;
    logic [LEVEL_W-1:0]  mean;
    logic [LEVEL_W-1:0]  peak;
    logic [TIME_W-1:0]   stamp;
    bit                  typed;
    logic                want_active;
    edge_t               want_edge;
    logic [LEVEL_W-1:0]  want_mean;
    logic [LEVEL_W-1:0]  want_peak;
  } stim_row_t;

  typedef enum {LVL_LOUD, LVL_QUIET, LVL_MID, LVL_NEAR, LVL_ANY} level_kind_e;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata = '0;   // mean_level, peak_level, time_ms
  logic                    in_tuser = 1'b0; // func
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;       // sound_active, edge_res, last_mean, last_peak, pad
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DAT_W-1:0]    cfg_data = '0;

  sound_activity_hysteresis_detector_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Detector state as the predictor sees it
  logic [LEVEL_W-1:0] reg_start_th = START_TH_RST;
  logic [LEVEL_W-1:0] reg_stop_th  = STOP_TH_RST;
  logic [RUN_W-1:0]   reg_debounce = DEBOUNCE_RST;
  logic [GRACE_W-1:0] reg_grace    = GRACE_RST;
  logic               det_active = 1'b0;
  logic               det_live = 1'b0;
  logic [RUN_W-1:0]   loud_run = '0;
  logic [RUN_W-1:0]   quiet_run = '0;
  logic [TIME_W-1:0]  window_start = '0;
  logic [LEVEL_W-1:0] held_mean = '0;
  logic [LEVEL_W-1:0] held_peak = '0;

  status_t            expected_status [$];
  int                 mismatch_cnt = 0;
  int                 send_calm = 0;
  int                 recv_calm = 0;
  int                 recv_stall = 0;
  logic [TIME_W-1:0]  gen_stamp;
  int                 seg_left;
  level_kind_e        seg_kind;

  function automatic status_t track_activity(input bit pause, input logic [LEVEL_W-1:0] mean,
                                             input logic [LEVEL_W-1:0] peak,
                                             input logic [TIME_W-1:0] stamp);
    status_t           res;
    logic [RUN_W-1:0]  need;
    logic [TIME_W-1:0] elapsed;
    need = (reg_debounce == '0) ? 8'd1 : reg_debounce;
    res.edge_code = EDGE_NONE;
    if (pause) begin
      det_live  = 1'b0;
      loud_run  = '0;
      quiet_run = '0;
    end else begin
      // first report after reset or pause rearms the grace window, no end edge
      if (!det_live) begin
        det_live     = 1'b1;
        window_start = stamp;
        loud_run     = '0;
        quiet_run    = '0;
        det_active   = 1'b0;
      end
      elapsed = stamp - window_start;
      if (!det_active) begin
        quiet_run = '0;
        if (mean >= reg_start_th) loud_run = (loud_run == 8'hFF) ? 8'hFF : loud_run + 8'd1;
        else loud_run = '0;
        if (elapsed >= {16'd0, reg_grace} && loud_run >= need) begin
          det_active    = 1'b1;
          loud_run      = '0;
          res.edge_code = EDGE_START;
        end
      end else begin
        loud_run = '0;
        if (mean <= reg_stop_th) quiet_run = (quiet_run == 8'hFF) ? 8'hFF : quiet_run + 8'd1;
        else quiet_run = '0;
        if (quiet_run >= need) begin
          det_active    = 1'b0;
          quiet_run     = '0;
          res.edge_code = EDGE_END;
        end
      end
      held_mean = mean;
      held_peak = peak;
    end
    res.active = det_active;
    res.mean   = held_mean;
    res.peak   = held_peak;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns  %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin : check_results
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("result word with none pending", out_tdata, 0);
      end else begin
        want = expected_status.pop_front();
        if (out_tdata[0] !== want.active)
          report_mismatch("sound_active", out_tdata[0], want.active);
        if (out_tdata[2:1] !== want.edge_code)
          report_mismatch("edge_res", out_tdata[2:1], want.edge_code);
        if (out_tdata[18:3] !== want.mean)
          report_mismatch("last_mean", out_tdata[18:3], want.mean);
        if (out_tdata[34:19] !== want.peak)
          report_mismatch("last_peak", out_tdata[34:19], want.peak);
      end
    end
  end

  // Receiver backpressure: short stalls mostly, a few long ones, some calm stretches
  always @(posedge clk) begin
    if (recv_stall > 0) begin
      out_tready <= 1'b0;
      recv_stall--;
    end else if (recv_calm > 0) begin
      out_tready <= 1'b1;
      recv_calm--;
    end else begin
      out_tready <= 1'b1;
      case ($urandom_range(99, 0)) inside
        [0:2]:   recv_calm = $urandom_range(100, 30);
        [3:26]:  recv_stall = $urandom_range(3, 1);
        [27:29]: recv_stall = $urandom_range(40, 8);
        default: ;
      endcase
    end
  end

  function automatic int pick_gap();
    int roll;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    roll = $urandom_range(99, 0);
    if (roll < 3) begin
      send_calm = $urandom_range(80, 20);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  task automatic send_word(input bit pause, input logic [LEVEL_W-1:0] mean,
                           input logic [LEVEL_W-1:0] peak, input logic [TIME_W-1:0] stamp,
                           input bit typed, input status_t typed_want);
    int      gap;
    status_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= pause;
    in_tdata  <= {stamp, peak, mean};
    do @(posedge clk); while (!in_tready);
    predicted = track_activity(pause, mean, peak, stamp);
    expected_status.push_back(typed ? typed_want : predicted);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    while (expected_status.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_status.size() != 0) begin
      report_mismatch("result words never arrived", expected_status.size(), 0);
      expected_status.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_TH: reg_start_th = value;
      CFG_STOP_TH:  reg_stop_th  = value;
      CFG_DEBOUNCE: reg_debounce = value[RUN_W-1:0];
      CFG_GRACE:    reg_grace    = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input int start_th, input int stop_th, input int debounce,
                            input int grace);
    write_reg(CFG_START_TH, start_th[CFG_DAT_W-1:0]);
    write_reg(CFG_STOP_TH, stop_th[CFG_DAT_W-1:0]);
    write_reg(CFG_DEBOUNCE, debounce[CFG_DAT_W-1:0]);
    write_reg(CFG_GRACE, grace[CFG_DAT_W-1:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level(input level_kind_e kind);
    int lvl;
    int start_th;
    int stop_th;
    start_th = reg_start_th;
    stop_th  = reg_stop_th;
    case (kind)
      LVL_LOUD:  lvl = $urandom_range(32768, start_th);
      LVL_QUIET: lvl = $urandom_range(stop_th, 0);
      LVL_MID: begin
        if (start_th > stop_th + 1) lvl = $urandom_range(start_th - 1, stop_th + 1);
        else lvl = $urandom_range(32768, 0);
      end
      LVL_NEAR: begin
        case ($urandom_range(3, 0))
          0:       lvl = start_th - 1;
          1:       lvl = start_th;
          2:       lvl = stop_th;
          default: lvl = stop_th + 1;
        endcase
        if (lvl < 0) lvl = 0;
        if (lvl > 32768) lvl = 32768;
      end
      default: begin
        case ($urandom_range(9, 0))
          0:       lvl = 0;
          1:       lvl = 32768;
          default: lvl = $urandom_range(32768, 0);
        endcase
      end
    endcase
    return lvl[LEVEL_W-1:0];
  endfunction

  // Streams of reports with rising timestamps, level bursts sized around the debounce count
  task automatic run_phase(input int n_items, input int pause_pct, input int step_max);
    int      need;
    int      roll;
    status_t unused;
    unused = '0;
    need = (reg_debounce == '0) ? 1 : reg_debounce;
    gen_stamp = ($urandom_range(4, 0) == 0) ? 32'hFFFF_FFFF - $urandom_range(3000, 0)
                                            : $urandom;
    seg_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) begin
        // hold the sender until the pipe is empty
        in_tvalid <= 1'b0;
        drain_results();
      end
      if ($urandom_range(99, 0) < pause_pct) begin
        send_word(1'b1, pick_level(LVL_ANY), pick_level(LVL_ANY), $urandom, 1'b0, unused);
        seg_left = 0;
      end else begin
        if (seg_left == 0) begin
          roll = $urandom_range(99, 0);
          if (roll < 35) seg_kind = LVL_LOUD;
          else if (roll < 70) seg_kind = LVL_QUIET;
          else if (roll < 80) seg_kind = LVL_MID;
          else if (roll < 90) seg_kind = LVL_NEAR;
          else seg_kind = LVL_ANY;
          seg_left = $urandom_range(need + 3, 1);
        end
        seg_left--;
        if ($urandom_range(49, 0) == 0) gen_stamp = gen_stamp + $urandom;
        else gen_stamp = gen_stamp + $urandom_range(step_max, 0);
        send_word(1'b0, pick_level(seg_kind), pick_level(LVL_ANY), gen_stamp, 1'b0, unused);
      end
    end
    in_tvalid <= 1'b0;
    drain_results();
  endtask

  // Defaults after reset: start 500, stop 300, debounce 3, grace 500 ms
  stim_row_t directed_rows [22] = '{
    '{1'b1, 16'd32768, 16'd32768, 32'hFFFF_FFFF, 1'b1, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd500,   16'd32768, 32'd1000,      1'b1, 1'b0, EDGE_NONE,  16'd500,   16'd32768},
    '{1'b0, 16'd32768, 16'd0,     32'd1200,      1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd600,   16'd700,   32'd1499,      1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd500,   16'd1,     32'd1500,      1'b1, 1'b1, EDGE_START, 16'd500,   16'd1},
    '{1'b0, 16'd300,   16'd300,   32'd1600,      1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd0,     16'd0,     32'd1700,      1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd301,   16'd5,     32'd1800,      1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd300,   16'd9,     32'd1900,      1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd0,     16'd0,     32'd2000,      1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd100,   16'd200,   32'd2100,      1'b1, 1'b0, EDGE_END,   16'd100,   16'd200},
    '{1'b0, 16'd1000,  16'd2000,  32'd2200,      1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd499,   16'd2000,  32'd2300,      1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd1000,  16'd2000,  32'd2400,      1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd1000,  16'd2000,  32'd2500,      1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd1000,  16'd4000,  32'd2600,      1'b1, 1'b1, EDGE_START, 16'd1000,  16'd4000},
    '{1'b1, 16'd7,     16'd9,     32'd0,         1'b1, 1'b1, EDGE_NONE,  16'd1000,  16'd4000},
    '{1'b0, 16'd32768, 16'd32768, 32'hFFFF_FF00, 1'b1, 1'b0, EDGE_NONE,  16'd32768, 16'd32768},
    '{1'b0, 16'd32768, 16'd12345, 32'hFFFF_FFFF, 1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd32768, 16'd0,     32'h0000_00F3, 1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0},
    '{1'b0, 16'd32768, 16'd0,     32'h0000_00F4, 1'b1, 1'b1, EDGE_START, 16'd32768, 16'd0},
    '{1'b0, 16'd400,   16'd3,     32'h0000_01F4, 1'b0, 1'b0, EDGE_NONE,  16'd0,     16'd0}
  };

  initial begin : stimulus
    int start_th;
    int stop_th;
    int debounce;
    int grace;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].pause, directed_rows[r].mean, directed_rows[r].peak,
                directed_rows[r].stamp, directed_rows[r].typed,
                {directed_rows[r].want_active, directed_rows[r].want_edge,
                 directed_rows[r].want_mean, directed_rows[r].want_peak});
    end
    in_tvalid <= 1'b0;
    drain_results();

    // zero debounce acts as one: flag toggles on nearly every report
    set_config(0, 32768, 0, 0);
    run_phase(120, 5, 50);
    // longest debounce and grace: loud streak saturates before the window opens
    set_config(0, 0, 255, 65535);
    run_phase(450, 0, 400);
    set_config(32768, 0, 1, 0);
    run_phase(100, 5, 100);

    repeat (8) begin
      start_th = ($urandom_range(1, 0) == 0) ? $urandom_range(4000, 0) : $urandom_range(32768, 0);
      stop_th  = ($urandom_range(9, 0) < 7) ? $urandom_range(start_th, 0)
                                           : $urandom_range(32768, 0);
      case ($urandom_range(9, 0))
        0:       debounce = $urandom_range(255, 0);
        1, 2:    debounce = $urandom_range(20, 7);
        default: debounce = $urandom_range(6, 1);
      endcase
      case ($urandom_range(4, 0))
        0:       grace = 0;
        1:       grace = $urandom_range(65535, 0);
        default: grace = $urandom_range(1000, 0);
      endcase
      set_config(start_th, stop_th, debounce, grace);
      run_phase(120, 3, $urandom_range(300, 20));
    end

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sahd_pkg.sv
rtl/sound_activity_hysteresis_detector_unit.sv
dv/tb_sound_activity_hysteresis_detector_unit.sv
